@@ design/chp_pkg.sv @@
// ----------------------------------------------------------------------------
// chp_pkg: shared types and constants for the cgi header line parser
// event and error codes, phase and number scanner states, result record
// ----------------------------------------------------------------------------
package chp_pkg;

    // line and name length limits
    localparam int LINE_LIMIT = 512;
    localparam int NAME_LIMIT = 512;
    localparam int LINE_W     = $clog2(LINE_LIMIT + 2);
    localparam int NAME_W     = $clog2(NAME_LIMIT + 1);

    // event codes
    localparam logic [2:0] EV_NAME   = 3'd0;
    localparam logic [2:0] EV_VALUE  = 3'd1;
    localparam logic [2:0] EV_LINE   = 3'd2;
    localparam logic [2:0] EV_STATUS = 3'd3;
    localparam logic [2:0] EV_BLOCK  = 3'd4;
    localparam logic [2:0] EV_BODY   = 3'd5;
    localparam logic [2:0] EV_ERROR  = 3'd6;

    // error codes
    localparam logic [2:0] ERR_LINE_LONG = 3'd0;
    localparam logic [2:0] ERR_NAME_LONG = 3'd1;
    localparam logic [2:0] ERR_EOL_NAME  = 3'd2;
    localparam logic [2:0] ERR_BARE_CR   = 3'd3;
    localparam logic [2:0] ERR_ZERO      = 3'd4;

    // characters
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // length of the word "status"
    localparam logic [2:0] STATUS_LEN  = 3'd6;
    localparam logic [2:0] MATCH_PAST  = 3'd7;

    typedef enum logic [4:0] {
        PH_NAME  = 5'b00001,
        PH_VALUE = 5'b00010,
        PH_CR    = 5'b00100,
        PH_BODY  = 5'b01000,
        PH_ERROR = 5'b10000
    } t_phase;

    typedef enum logic [6:0] {
        NUM_IDLE      = 7'b0000001,
        NUM_SIGN_POS  = 7'b0000010,
        NUM_SIGN_NEG  = 7'b0000100,
        NUM_DIG_POS   = 7'b0001000,
        NUM_DIG_NEG   = 7'b0010000,
        NUM_DONE_NONE = 7'b0100000,
        NUM_DONE_OK   = 7'b1000000
    } t_num;

    typedef struct packed {
        logic [2:0]         ev;
        logic [7:0]         data;
        logic signed [15:0] status;
        logic               status_ok;
        logic [2:0]         err;
    } t_result;

    // ascii upper to lower case
    function automatic logic [7:0] fold(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5a) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

    // letters of "status" by position
    function automatic logic [7:0] status_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h73;
            3'd1:    c = 8'h74;
            3'd2:    c = 8'h61;
            3'd3:    c = 8'h74;
            3'd4:    c = 8'h75;
            3'd5:    c = 8'h73;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ design/cgi_header_line_parser.sv @@
// ----------------------------------------------------------------------------
// cgi_header_line_parser: splits script output into header events and body
// one byte in, at most one event out per byte
// ----------------------------------------------------------------------------
// usage:
//   the input stream carries one script output byte per word on i_s_tdata.
//   each accepted byte is decoded in the same cycle against the parser state
//   and its event, if any, is written into the output register, or into the
//   skid register while the receiver stalls.
//   bytes that give no event (the name colon, dropped spaces and cr) leave
//   the output untouched.
//   throughput is one byte per cycle while the skid register is empty.
//   a skid register behind the output register absorbs one event when the
//   receiver stalls; o_s_tready drops only while the skid register is full.
//   i_cfg_we writes the lower-case name flag; do it between streams only.
//   synchronous reset returns to the start of a header block, clears the
//   sticky error and the lower-case flag, and empties both output registers.
// ----------------------------------------------------------------------------
module cgi_header_line_parser import chp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,    // lowercase_names
    // byte stream in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,      // [7:0] data_byte
    // event stream out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,      // [7:0] byte_out, [23:8] status_value,
                                        // [24] status_valid, [27:25] error_code
    output logic [2:0]  o_m_tuser       // [2:0] event_res
);

    logic    r_lower;
    logic    accept;
    logic    has_result;
    t_result res;

    // output register and skid register
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= 1'b0;
        end else if (i_cfg_we) begin
            r_lower <= i_cfg_wdata;
        end
    end

    // stop taking bytes only when the skid register holds an event
    assign o_s_tready = !r_skid_valid;
    assign accept     = i_s_tvalid && o_s_tready;

    chp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lower      (r_lower),
        .i_accept     (accept),
        .i_byte       (i_s_tdata),
        .o_has_result (has_result),
        .o_res        (res)
    );

    assign pop = r_out_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            // output slot free this cycle
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept && has_result;
            end
        end else if (accept && has_result) begin
            // receiver stalled, park the new event
            r_skid_valid <= 1'b1;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : res;
        end
        if (r_out_valid && !pop && !r_skid_valid) begin
            r_skid <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.ev;
    assign o_m_tdata  = {4'd0, r_out.err, r_out.status_ok, r_out.status, r_out.data};

endmodule

@@ design/chp_parse.sv @@
// ----------------------------------------------------------------------------
// chp_parse: per-byte header parser state and result decode
// state advances on each accepted byte, result is combinational from it
// ----------------------------------------------------------------------------
module chp_parse import chp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_lower,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_has_result,
    output t_result    o_res
);

    t_phase             r_phase, n_phase;
    logic [LINE_W-1:0]  r_line_bytes, n_line_bytes;
    logic [NAME_W-1:0]  r_name_len, n_name_len;
    logic               r_started, n_started;
    logic [2:0]         r_match_pos, n_match_pos;
    logic               r_match_ok, n_match_ok;
    logic signed [15:0] r_accum, n_accum;
    t_num               r_num, n_num;
    logic [2:0]         r_err, n_err;

    logic               digit;
    logic [4:0]         dval;
    logic signed [20:0] acc10;
    logic signed [20:0] acc_up, acc_dn;
    logic [NAME_W-1:0]  name_inc;
    logic               status_ok;

    assign digit    = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign dval     = {1'b0, i_byte[3:0]};
    assign acc10    = (21'(r_accum) <<< 3) + (21'(r_accum) <<< 1);
    assign acc_up   = acc10 + $signed({16'd0, dval});
    assign acc_dn   = acc10 - $signed({16'd0, dval});
    assign name_inc = r_name_len + 1'b1;
    assign status_ok = (r_num == NUM_DIG_POS) || (r_num == NUM_DIG_NEG)
                    || (r_num == NUM_DONE_OK);

    always_comb begin
        n_phase      = r_phase;
        n_line_bytes = r_line_bytes;
        n_name_len   = r_name_len;
        n_started    = r_started;
        n_match_pos  = r_match_pos;
        n_match_ok   = r_match_ok;
        n_accum      = r_accum;
        n_num        = r_num;
        n_err        = r_err;
        o_has_result = 1'b0;
        o_res        = '0;

        unique case (r_phase)
            PH_BODY: begin
                o_has_result = 1'b1;
                o_res.ev     = EV_BODY;
                o_res.data   = i_byte;
            end
            PH_CR: begin
                o_has_result = 1'b1;
                if (i_byte == CH_LF) begin
                    n_phase  = PH_BODY;
                    o_res.ev = EV_BLOCK;
                end else begin
                    n_phase   = PH_ERROR;
                    n_err     = ERR_BARE_CR;
                    o_res.ev  = EV_ERROR;
                    o_res.err = ERR_BARE_CR;
                end
            end
            PH_NAME: begin
                if (r_line_bytes > LINE_W'(LINE_LIMIT)) begin
                    o_has_result = 1'b1;
                    n_phase      = PH_ERROR;
                    n_err        = ERR_LINE_LONG;
                    o_res.ev     = EV_ERROR;
                    o_res.err    = ERR_LINE_LONG;
                end else begin
                    n_line_bytes = r_line_bytes + 1'b1;
                    if (i_byte == CH_COLON) begin
                        n_phase = PH_VALUE;
                    end else if (i_byte == CH_CR || i_byte == CH_LF) begin
                        if (r_name_len != '0) begin
                            o_has_result = 1'b1;
                            n_phase      = PH_ERROR;
                            n_err        = ERR_EOL_NAME;
                            o_res.ev     = EV_ERROR;
                            o_res.err    = ERR_EOL_NAME;
                        end else if (i_byte == CH_CR) begin
                            n_phase = PH_CR;
                        end else begin
                            o_has_result = 1'b1;
                            n_phase      = PH_BODY;
                            o_res.ev     = EV_BLOCK;
                        end
                    end else if (i_byte == CH_NUL) begin
                        o_has_result = 1'b1;
                        n_phase      = PH_ERROR;
                        n_err        = ERR_ZERO;
                        o_res.ev     = EV_ERROR;
                        o_res.err    = ERR_ZERO;
                    end else begin
                        n_name_len   = name_inc;
                        o_has_result = 1'b1;
                        if (name_inc >= NAME_W'(NAME_LIMIT)) begin
                            n_phase   = PH_ERROR;
                            n_err     = ERR_NAME_LONG;
                            o_res.ev  = EV_ERROR;
                            o_res.err = ERR_NAME_LONG;
                        end else begin
                            if (r_match_pos < STATUS_LEN) begin
                                if (fold(i_byte) != status_char(r_match_pos)) begin
                                    n_match_ok = 1'b0;
                                end
                                n_match_pos = r_match_pos + 1'b1;
                            end else begin
                                n_match_ok  = 1'b0;
                                n_match_pos = MATCH_PAST;
                            end
                            o_res.ev   = EV_NAME;
                            o_res.data = i_lower ? fold(i_byte) : i_byte;
                        end
                    end
                end
            end
            PH_VALUE: begin
                if (r_line_bytes > LINE_W'(LINE_LIMIT)) begin
                    o_has_result = 1'b1;
                    n_phase      = PH_ERROR;
                    n_err        = ERR_LINE_LONG;
                    o_res.ev     = EV_ERROR;
                    o_res.err    = ERR_LINE_LONG;
                end else begin
                    n_line_bytes = r_line_bytes + 1'b1;
                    if (i_byte == CH_CR) begin
                        // cr inside a value is dropped
                    end else if (i_byte == CH_LF) begin
                        o_has_result = 1'b1;
                        if (r_match_ok && r_match_pos == STATUS_LEN) begin
                            o_res.ev        = EV_STATUS;
                            o_res.status    = status_ok ? r_accum : 16'sd0;
                            o_res.status_ok = status_ok;
                        end else begin
                            o_res.ev = EV_LINE;
                        end
                        n_phase      = PH_NAME;
                        n_line_bytes = '0;
                        n_name_len   = '0;
                        n_started    = 1'b0;
                        n_match_pos  = '0;
                        n_match_ok   = 1'b1;
                        n_accum      = '0;
                        n_num        = NUM_IDLE;
                    end else if (i_byte == CH_NUL) begin
                        o_has_result = 1'b1;
                        n_phase      = PH_ERROR;
                        n_err        = ERR_ZERO;
                        o_res.ev     = EV_ERROR;
                        o_res.err    = ERR_ZERO;
                    end else if (i_byte == CH_SPACE && !r_started) begin
                        // leading space dropped
                    end else begin
                        n_started    = 1'b1;
                        o_has_result = 1'b1;
                        o_res.ev     = EV_VALUE;
                        o_res.data   = i_byte;
                        // number scanner
                        unique case (r_num)
                            NUM_IDLE: begin
                                if (i_byte == CH_SPACE || i_byte == CH_TAB
                                        || i_byte == CH_VT || i_byte == CH_FF) begin
                                    n_num = NUM_IDLE;
                                end else if (i_byte == CH_PLUS) begin
                                    n_num = NUM_SIGN_POS;
                                end else if (i_byte == CH_MINUS) begin
                                    n_num = NUM_SIGN_NEG;
                                end else if (digit) begin
                                    n_accum = 16'(dval);
                                    n_num   = NUM_DIG_POS;
                                end else begin
                                    n_num = NUM_DONE_NONE;
                                end
                            end
                            NUM_SIGN_POS, NUM_SIGN_NEG: begin
                                if (digit) begin
                                    if (r_num == NUM_SIGN_NEG) begin
                                        n_accum = -$signed(16'(dval));
                                        n_num   = NUM_DIG_NEG;
                                    end else begin
                                        n_accum = 16'(dval);
                                        n_num   = NUM_DIG_POS;
                                    end
                                end else begin
                                    n_num = NUM_DONE_NONE;
                                end
                            end
                            NUM_DIG_POS: begin
                                if (!digit) begin
                                    n_num = NUM_DONE_OK;
                                end else if (acc_up > 21'sd32767) begin
                                    n_accum = 16'sh7fff;
                                end else begin
                                    n_accum = acc_up[15:0];
                                end
                            end
                            NUM_DIG_NEG: begin
                                if (!digit) begin
                                    n_num = NUM_DONE_OK;
                                end else if (acc_dn < -21'sd32768) begin
                                    n_accum = 16'sh8000;
                                end else begin
                                    n_accum = acc_dn[15:0];
                                end
                            end
                            default: begin
                                n_num = r_num;
                            end
                        endcase
                    end
                end
            end
            PH_ERROR: begin
                o_has_result = 1'b1;
                o_res.ev     = EV_ERROR;
                o_res.err    = r_err;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_NAME;
            r_line_bytes <= '0;
            r_name_len   <= '0;
            r_started    <= 1'b0;
            r_match_pos  <= '0;
            r_match_ok   <= 1'b1;
            r_accum      <= '0;
            r_num        <= NUM_IDLE;
            r_err        <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_line_bytes <= n_line_bytes;
            r_name_len   <= n_name_len;
            r_started    <= n_started;
            r_match_pos  <= n_match_pos;
            r_match_ok   <= n_match_ok;
            r_accum      <= n_accum;
            r_num        <= n_num;
            r_err        <= n_err;
        end
    end

endmodule

@@ tb/tb_cgi_header_line_parser.sv @@
// ----------------------------------------------------------------------------
// tb_cgi_header_line_parser: self-checking bench for the cgi header parser
// streams header lines, one header block end and a body or error tail through
// the parser, predicts each output event in a scoreboard and compares the
// event stream field by field under random stalls on both sides
// ----------------------------------------------------------------------------
module tb_cgi_header_line_parser;
    import chp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int EVENT_LATENCY = 2;       // byte to event, plus the skid stage
    localparam int CYCLE_LIMIT   = 400000;
    localparam int CHUNK_BYTES   = 25;      // header byte budget per random chunk
    localparam int HOLD_AT       = 30;      // events seen before the long sink stall
    localparam int HOLD_CYCLES   = 60;

    // ways the header block can end; only one per run since errors and the
    // body phase both last until reset
    typedef enum int {
        END_LF, END_CRLF, END_LINE_LONG, END_NAME_LONG, END_EOL_NAME, END_BARE_CR, END_ZERO
    } t_ending;

    // ------------------------------------------------------------------------
    // scoreboard: parser state copy, expected events, event checks
    // ------------------------------------------------------------------------
    class header_event_board;
        bit         lowercase;
        t_phase     phase;
        int         line_count;
        int         name_count;
        bit         value_started;
        int         match_pos;
        bit         match_ok;
        int         number;
        t_num       scan_state;
        logic [2:0] kept_err;
        t_result    expected_events[$];
        int         errors;
        int         results_seen;

        function new();
            lowercase = 1'b0;
            phase     = PH_NAME;
            kept_err  = ERR_LINE_LONG;
            errors    = 0;
            results_seen = 0;
            start_line();
        endfunction

        function void start_line();
            line_count    = 0;
            name_count    = 0;
            value_started = 1'b0;
            match_pos     = 0;
            match_ok      = 1'b1;
            number        = 0;
            scan_state    = NUM_IDLE;
        endfunction

        function void push_event(logic [2:0] ev, logic [7:0] data, logic [15:0] status,
                                 logic ok, logic [2:0] err);
            t_result r;
            r.ev        = ev;
            r.data      = data;
            r.status    = status;
            r.status_ok = ok;
            r.err       = err;
            expected_events.push_back(r);
        endfunction

        function void go_error(logic [2:0] code);
            phase    = PH_ERROR;
            kept_err = code;
            push_event(EV_ERROR, 8'h00, 16'h0000, 1'b0, code);
        endfunction

        // leading blanks, one sign, saturating decimal digits
        function void scan_status(logic [7:0] b);
            bit is_digit;
            int d;
            is_digit = (b >= 8'h30 && b <= 8'h39);
            d = int'(b) - 48;
            case (scan_state)
                NUM_IDLE: begin
                    if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF) begin
                        // still skipping blanks
                    end else if (b == CH_PLUS) begin
                        scan_state = NUM_SIGN_POS;
                    end else if (b == CH_MINUS) begin
                        scan_state = NUM_SIGN_NEG;
                    end else if (is_digit) begin
                        number = d;
                        scan_state = NUM_DIG_POS;
                    end else begin
                        scan_state = NUM_DONE_NONE;
                    end
                end
                NUM_SIGN_POS, NUM_SIGN_NEG: begin
                    if (!is_digit) begin
                        scan_state = NUM_DONE_NONE;
                    end else if (scan_state == NUM_SIGN_NEG) begin
                        number = -d;
                        scan_state = NUM_DIG_NEG;
                    end else begin
                        number = d;
                        scan_state = NUM_DIG_POS;
                    end
                end
                NUM_DIG_POS: begin
                    if (!is_digit) begin
                        scan_state = NUM_DONE_OK;
                    end else begin
                        number = number * 10 + d;
                        if (number > 32767) number = 32767;
                    end
                end
                NUM_DIG_NEG: begin
                    if (!is_digit) begin
                        scan_state = NUM_DONE_OK;
                    end else begin
                        number = number * 10 - d;
                        if (number < -32768) number = -32768;
                    end
                end
                default: begin
                end
            endcase
        endfunction

        // one accepted input byte: advance the state, queue its event if any
        function void predict_byte(logic [7:0] b);
            logic [7:0] lower;
            string      word;
            bit         ok;
            word  = "status";
            lower = (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
            case (phase)
                PH_BODY: push_event(EV_BODY, b, 16'h0000, 1'b0, 3'd0);
                PH_CR: begin
                    if (b == CH_LF) begin
                        phase = PH_BODY;
                        push_event(EV_BLOCK, 8'h00, 16'h0000, 1'b0, 3'd0);
                    end else begin
                        go_error(ERR_BARE_CR);
                    end
                end
                PH_NAME: begin
                    if (line_count > LINE_LIMIT) begin
                        go_error(ERR_LINE_LONG);
                        return;
                    end
                    line_count++;
                    if (b == CH_COLON) begin
                        phase = PH_VALUE;
                    end else if (b == CH_CR || b == CH_LF) begin
                        if (name_count != 0) begin
                            go_error(ERR_EOL_NAME);
                        end else if (b == CH_CR) begin
                            phase = PH_CR;
                        end else begin
                            phase = PH_BODY;
                            push_event(EV_BLOCK, 8'h00, 16'h0000, 1'b0, 3'd0);
                        end
                    end else if (b == CH_NUL) begin
                        go_error(ERR_ZERO);
                    end else begin
                        name_count++;
                        if (name_count >= NAME_LIMIT) begin
                            go_error(ERR_NAME_LONG);
                            return;
                        end
                        if (match_pos < 6) begin
                            if (lower != word[match_pos]) match_ok = 1'b0;
                            match_pos++;
                        end else begin
                            match_ok  = 1'b0;
                            match_pos = 7;
                        end
                        push_event(EV_NAME, lowercase ? lower : b, 16'h0000, 1'b0, 3'd0);
                    end
                end
                PH_VALUE: begin
                    if (line_count > LINE_LIMIT) begin
                        go_error(ERR_LINE_LONG);
                        return;
                    end
                    line_count++;
                    if (b == CH_CR) begin
                        // cr inside a value is dropped
                    end else if (b == CH_LF) begin
                        if (match_ok && match_pos == 6) begin
                            ok = (scan_state == NUM_DIG_POS || scan_state == NUM_DIG_NEG ||
                                  scan_state == NUM_DONE_OK);
                            push_event(EV_STATUS, 8'h00, ok ? number[15:0] : 16'h0000, ok, 3'd0);
                        end else begin
                            push_event(EV_LINE, 8'h00, 16'h0000, 1'b0, 3'd0);
                        end
                        phase = PH_NAME;
                        start_line();
                    end else if (b == CH_NUL) begin
                        go_error(ERR_ZERO);
                    end else if (b == CH_SPACE && !value_started) begin
                        // leading space dropped
                    end else begin
                        value_started = 1'b1;
                        scan_status(b);
                        push_event(EV_VALUE, b, 16'h0000, 1'b0, 3'd0);
                    end
                end
                default: push_event(EV_ERROR, 8'h00, 16'h0000, 1'b0, kept_err);
            endcase
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] seen);
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, seen);
        endfunction

        // one accepted output word against the oldest expectation
        function void check_event(t_result got, logic [3:0] pad);
            t_result want;
            results_seen++;
            if (expected_events.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected event %0h, expected nothing, got data %0h",
                         $time, got.ev, got.data);
                return;
            end
            want = expected_events.pop_front();
            if (got.ev !== want.ev)               report("event", want.ev, got.ev);
            if (got.data !== want.data)           report("byte", want.data, got.data);
            if (got.status !== want.status)       report("status value", want.status, got.status);
            if (got.status_ok !== want.status_ok) report("status valid", want.status_ok,
                                                         got.status_ok);
            if (got.err !== want.err)             report("error code", want.err, got.err);
            if (pad !== 4'h0)                     report("tdata pad", 4'h0, pad);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // dut and its ports
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic [2:0]  o_m_tuser;

    cgi_header_line_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    header_event_board board;
    logic [7:0]        pending_bytes[$];   // bytes of the line being built
    bit                burst_mode;         // sender offers a word every cycle
    int                cycle_count;
    int                sink_stall;
    int                sink_roll;
    bit                hold_done;

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_cgi_header_line_parser: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: both handshakes sampled at the rising edge, so the values seen
    // are the ones from before the edge's register updates
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            // the event at this edge comes from an earlier byte, so check first
            if (o_m_tvalid && i_m_tready) begin
                got.ev        = o_m_tuser;
                got.data      = o_m_tdata[7:0];
                got.status    = o_m_tdata[23:8];
                got.status_ok = o_m_tdata[24];
                got.err       = o_m_tdata[27:25];
                board.check_event(got, o_m_tdata[31:28]);
            end
            if (i_s_tvalid && o_s_tready) board.predict_byte(i_s_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // event sink: mostly short stalls, a few long ones, one very long hold
    // that fills the parser and pushes back on the byte input, and a window
    // of events with no stalls at all
    // ------------------------------------------------------------------------
    initial begin
        sink_stall = 0;
        hold_done  = 1'b0;
    end

    always @(negedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall--;
            i_m_tready <= 1'b0;
        end else if (!hold_done && board.results_seen >= HOLD_AT) begin
            hold_done  = 1'b1;
            sink_stall = HOLD_CYCLES - 1;
            i_m_tready <= 1'b0;
        end else if (board.results_seen >= 300 && board.results_seen < 450) begin
            i_m_tready <= 1'b1;
        end else begin
            sink_roll = $urandom_range(0, 99);
            if (sink_roll < 65) begin
                i_m_tready <= 1'b1;
            end else begin
                // short stall most of the time, now and then a long one
                sink_stall = (sink_roll < 93) ? $urandom_range(0, 2) : $urandom_range(8, 30);
                i_m_tready <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // byte source helpers
    // ------------------------------------------------------------------------

    // name byte: letters of both cases for the fold, or anything that keeps
    // the line well formed
    function automatic logic [7:0] pick_name_byte();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:       b = 8'h41 + 8'($urandom_range(0, 25));
            1:       b = 8'h61 + 8'($urandom_range(0, 25));
            default: begin
                do b = 8'($urandom_range(1, 255));
                while (b == CH_COLON || b == CH_CR || b == CH_LF);
            end
        endcase
        return b;
    endfunction

    // value byte: anything but lf and zero, cr included since it is dropped
    function automatic logic [7:0] pick_value_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == CH_LF);
        return b;
    endfunction

    task automatic push_text(input string s);
        foreach (s[i]) pending_bytes.push_back(s[i]);
    endtask

    // offer one word after a random gap, return at the falling edge after
    // it was taken without having driven anything there yet
    task automatic send_byte(input logic [7:0] b);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_mode || roll < 55) gap = 0;
        else if (roll < 90)          gap = $urandom_range(1, 3);
        else if (roll < 98)          gap = $urandom_range(4, 10);
        else                         gap = $urandom_range(20, 40);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 8'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic send_pending();
        while (pending_bytes.size() != 0) send_byte(pending_bytes.pop_front());
    endtask

    // sender idles until every event is out, then waits for any byte that
    // gives no event to clear the pipe
    task automatic drain_events();
        i_s_tvalid <= 1'b0;
        while (board.expected_events.size() != 0) @(negedge i_clk);
        repeat (EVENT_LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic write_lowercase(input bit v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        board.lowercase = v;
    endtask

    // one well formed header line: status lines with random case, blanks,
    // sign, digit count and trailing junk; near-miss status names; empty
    // names; generic lines; each ends with lf or cr lf
    task automatic build_header_line();
        int         roll;
        string      word;
        logic [7:0] blanks[4];
        blanks = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
        roll   = $urandom_range(0, 9);
        if (roll < 4) begin
            word = "status";
            if (roll == 3) begin
                case ($urandom_range(0, 2))
                    0:       word = "statu";
                    1:       word = "statuss";
                    default: word = "stetus";
                endcase
            end
            foreach (word[i]) begin
                pending_bytes.push_back($urandom_range(0, 1) ? word[i] - 8'd32 : word[i]);
            end
            pending_bytes.push_back(CH_COLON);
            repeat ($urandom_range(0, 2)) pending_bytes.push_back(CH_SPACE);
            repeat ($urandom_range(0, 2)) pending_bytes.push_back(blanks[$urandom_range(0, 3)]);
            case ($urandom_range(0, 3))
                1:       pending_bytes.push_back(CH_PLUS);
                2:       pending_bytes.push_back(CH_MINUS);
                default: begin
                end
            endcase
            // long digit runs hit the saturation on both signs
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4)) begin
                pending_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
            end
            repeat ($urandom_range(0, 2)) pending_bytes.push_back(pick_value_byte());
        end else begin
            // an empty name is still a header line
            if (roll != 4) begin
                repeat ($urandom_range(1, 12)) pending_bytes.push_back(pick_name_byte());
            end
            pending_bytes.push_back(CH_COLON);
            repeat ($urandom_range(0, 2)) pending_bytes.push_back(CH_SPACE);
            repeat ($urandom_range(0, 16)) pending_bytes.push_back(pick_value_byte());
        end
        if ($urandom_range(0, 1)) pending_bytes.push_back(CH_CR);
        pending_bytes.push_back(CH_LF);
    endtask

    task automatic send_header_lines(input int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            build_header_line();
            sent += pending_bytes.size();
            send_pending();
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_ending    ending;
        logic [7:0] b;

        board       = new();
        burst_mode  = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = 8'h00;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed lines with names kept as sent: empty name and value,
        // mixed case status with blanks and a saturating negative number,
        // name byte extremes with a dropped cr in the value
        push_text(":\n");
        push_text("StAtUs: \t-40000\n");
        pending_bytes.push_back(8'h7f);
        pending_bytes.push_back(8'h80);
        pending_bytes.push_back(CH_COLON);
        pending_bytes.push_back(8'hff);
        pending_bytes.push_back(CH_CR);
        pending_bytes.push_back(CH_LF);
        send_pending();
        drain_events();

        // lower-case names, gaps on the sender; the long sink hold lands here
        write_lowercase(1'b1);
        send_header_lines(CHUNK_BYTES);
        drain_events();

        // names as sent, sender offers every cycle
        write_lowercase(1'b0);
        burst_mode = 1'b1;
        send_header_lines(CHUNK_BYTES);
        burst_mode = 1'b0;
        drain_events();

        // the long endings already run one line up to the limits, so the
        // longest legal line goes with the short endings
        ending = t_ending'($urandom_range(0, 6));

        // longest legal name and longest legal line: 511 name bytes, colon, lf
        write_lowercase(1'($urandom_range(0, 1)));
        if (ending != END_LINE_LONG && ending != END_NAME_LONG) begin
            repeat (NAME_LIMIT - 1) pending_bytes.push_back(pick_name_byte());
            pending_bytes.push_back(CH_COLON);
            pending_bytes.push_back(CH_LF);
            send_pending();
        end
        send_header_lines(CHUNK_BYTES);
        drain_events();

        // close the header block, either into the body or into one of the
        // sticky errors, then keep streaming random bytes
        write_lowercase(1'b1);
        case (ending)
            END_LF: pending_bytes.push_back(CH_LF);
            END_CRLF: begin
                pending_bytes.push_back(CH_CR);
                pending_bytes.push_back(CH_LF);
            end
            END_LINE_LONG: begin
                repeat (3) pending_bytes.push_back(pick_name_byte());
                pending_bytes.push_back(CH_COLON);
                repeat (LINE_LIMIT + 3) pending_bytes.push_back(pick_value_byte());
            end
            END_NAME_LONG: begin
                repeat (NAME_LIMIT) pending_bytes.push_back(pick_name_byte());
            end
            END_EOL_NAME: begin
                repeat ($urandom_range(1, 5)) pending_bytes.push_back(pick_name_byte());
                pending_bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
            end
            END_BARE_CR: begin
                // any byte but lf after a line-start cr, zero included
                pending_bytes.push_back(CH_CR);
                do b = 8'($urandom_range(0, 255));
                while (b == CH_LF);
                pending_bytes.push_back(b);
            end
            default: begin
                // zero byte in the name or in the value
                if ($urandom_range(0, 1)) begin
                    repeat ($urandom_range(0, 3)) pending_bytes.push_back(pick_name_byte());
                end else begin
                    repeat (2) pending_bytes.push_back(pick_name_byte());
                    pending_bytes.push_back(CH_COLON);
                    repeat ($urandom_range(0, 4)) pending_bytes.push_back(pick_value_byte());
                end
                pending_bytes.push_back(CH_NUL);
            end
        endcase
        // body bytes pass through as is, zero included; after an error every
        // byte repeats the first error code
        repeat ((ending == END_LF || ending == END_CRLF) ? 80 : 40) begin
            pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
        send_pending();
        drain_events();

        // room for any stray event after the last expected one
        repeat (EVENT_LATENCY + 6) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("tb_cgi_header_line_parser: clean");
        end else begin
            $display("tb_cgi_header_line_parser: errors");
        end
        $finish;
    end

endmodule
